[src/wpe_pkg.sv]
// Shared types, constants and register map for the pixel pulse encoder.
// Used by every module of the block and by its port checker.
package wpe_pkg;

    localparam int CHAN_W         = 8;
    localparam int BITS_PER_PIXEL = 3 * CHAN_W;
    localparam int BIT_IDX_W      = $clog2(BITS_PER_PIXEL);
    localparam int PROD_W         = 2 * CHAN_W;
    localparam int TICK_W         = 8;
    localparam int LATCH_W        = 16;
    localparam int NUM_LANES      = 3;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;
    localparam int ROUND_BIAS     = 127;

    localparam logic [CHAN_W-1:0]  BRIGHTNESS_RST = 8'd64;
    localparam logic [TICK_W-1:0]  ONE_HIGH_RST   = 8'd20;
    localparam logic [TICK_W-1:0]  ONE_LOW_RST    = 8'd10;
    localparam logic [TICK_W-1:0]  ZERO_HIGH_RST  = 8'd9;
    localparam logic [TICK_W-1:0]  ZERO_LOW_RST   = 8'd21;
    localparam logic [LATCH_W-1:0] LATCH_RST      = 16'd7200;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_LATCH = 1'b1;

    typedef enum logic [2:0] {
        REG_BRIGHTNESS = 3'd0,
        REG_ONE_HIGH   = 3'd1,
        REG_ONE_LOW    = 3'd2,
        REG_ZERO_HIGH  = 3'd3,
        REG_ZERO_LOW   = 3'd4,
        REG_LATCH      = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic              kind;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_in_word;

    typedef struct packed {
        logic [TICK_W-1:0]  high_ticks;
        logic [LATCH_W-1:0] low_ticks;
        logic               bit_value;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic [CHAN_W-1:0]  brightness;
        logic [TICK_W-1:0]  one_high_ticks;
        logic [TICK_W-1:0]  one_low_ticks;
        logic [TICK_W-1:0]  zero_high_ticks;
        logic [TICK_W-1:0]  zero_low_ticks;
        logic [LATCH_W-1:0] latch_ticks;
    } t_cfg;

    typedef struct packed {
        logic mul_en;
        logic div_en;
    } t_lane_ctrl;

endpackage

[src/wpe_regs.sv]
// APB register file holding brightness, pulse timing and latch hold.
// Depends on wpe_pkg for the register map and the configuration struct.
module wpe_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wpe_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wpe_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wpe_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output wpe_pkg::t_cfg                      o_cfg
);
    import wpe_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_BRIGHTNESS: n_cfg.brightness      = pwdata[CHAN_W-1:0];
                REG_ONE_HIGH:   n_cfg.one_high_ticks  = pwdata[TICK_W-1:0];
                REG_ONE_LOW:    n_cfg.one_low_ticks   = pwdata[TICK_W-1:0];
                REG_ZERO_HIGH:  n_cfg.zero_high_ticks = pwdata[TICK_W-1:0];
                REG_ZERO_LOW:   n_cfg.zero_low_ticks  = pwdata[TICK_W-1:0];
                REG_LATCH:      n_cfg.latch_ticks     = pwdata[LATCH_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BRIGHTNESS: prdata = APB_DATA_W'(r_cfg.brightness);
            REG_ONE_HIGH:   prdata = APB_DATA_W'(r_cfg.one_high_ticks);
            REG_ONE_LOW:    prdata = APB_DATA_W'(r_cfg.one_low_ticks);
            REG_ZERO_HIGH:  prdata = APB_DATA_W'(r_cfg.zero_high_ticks);
            REG_ZERO_LOW:   prdata = APB_DATA_W'(r_cfg.zero_low_ticks);
            REG_LATCH:      prdata = APB_DATA_W'(r_cfg.latch_ticks);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness      <= BRIGHTNESS_RST;
            r_cfg.one_high_ticks  <= ONE_HIGH_RST;
            r_cfg.one_low_ticks   <= ONE_LOW_RST;
            r_cfg.zero_high_ticks <= ZERO_HIGH_RST;
            r_cfg.zero_low_ticks  <= ZERO_LOW_RST;
            r_cfg.latch_ticks     <= LATCH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[src/wpe_lane.sv]
// One color channel scaler: multiply by brightness, then divide by 255.
// Depends on wpe_pkg for widths and the lane control struct.
module wpe_lane (
    input  logic                          i_clk,
    input  logic [wpe_pkg::CHAN_W-1:0]    i_value,
    input  logic [wpe_pkg::CHAN_W-1:0]    i_brightness,
    input  wpe_pkg::t_lane_ctrl           i_ctrl,
    output logic [wpe_pkg::CHAN_W-1:0]    o_scaled
);
    import wpe_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W:0]   quot_sum;
    logic [CHAN_W-1:0] r_scaled;

    assign n_prod = ({{CHAN_W{1'b0}}, i_value} * {{CHAN_W{1'b0}}, i_brightness})
                  + PROD_W'(ROUND_BIAS);

    // For x = 255q + r with q <= 255, (x + (x >> 8) + 1) >> 8 equals q exactly.
    assign quot_sum = {1'b0, r_prod} + (PROD_W+1)'(r_prod[PROD_W-1:CHAN_W]) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_ctrl.div_en) begin
            r_scaled <= quot_sum[PROD_W-1:CHAN_W];
        end
    end

    assign o_scaled = r_scaled;

endmodule

[src/wpe_serializer.sv]
// Takes the three scaled lanes as one word and sends one pulse word per cycle unless stalled.
// Depends on wpe_pkg for the output word and configuration structs.
module wpe_serializer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load_valid,
    input  logic                                i_load_kind,
    input  logic [wpe_pkg::BITS_PER_PIXEL-1:0]  i_load_word,
    input  wpe_pkg::t_cfg                       i_cfg,
    input  logic                                i_out_stall,
    output logic                                o_take,
    output logic                                o_out_valid,
    output wpe_pkg::t_out_word                  o_out_data
);
    import wpe_pkg::*;

    logic                      r_valid;
    logic                      r_kind;
    logic [BITS_PER_PIXEL-1:0] r_word;
    logic [BIT_IDX_W-1:0]      r_idx;
    logic                      is_last;
    logic                      cur_bit;
    logic                      load;

    assign is_last = (r_kind == KIND_LATCH) || (r_idx == BIT_IDX_W'(BITS_PER_PIXEL - 1));
    assign cur_bit = (r_kind == KIND_PIXEL) && r_word[BITS_PER_PIXEL-1];

    // A new word is taken when nothing is held or the final pulse leaves now.
    assign o_take = !r_valid || (!i_out_stall && is_last);
    assign load   = o_take && i_load_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_load_kind;
            r_word <= i_load_word;
            r_idx  <= '0;
        end else if (r_valid && !i_out_stall) begin
            r_word <= {r_word[BITS_PER_PIXEL-2:0], 1'b0};
            r_idx  <= r_idx + 1'b1;
        end
    end

    always_comb begin
        o_out_data.bit_value = cur_bit;
        o_out_data.last      = is_last;
        if (r_kind == KIND_LATCH) begin
            o_out_data.high_ticks = '0;
            o_out_data.low_ticks  = i_cfg.latch_ticks;
        end else if (cur_bit) begin
            o_out_data.high_ticks = i_cfg.one_high_ticks;
            o_out_data.low_ticks  = LATCH_W'(i_cfg.one_low_ticks);
        end else begin
            o_out_data.high_ticks = i_cfg.zero_high_ticks;
            o_out_data.low_ticks  = LATCH_W'(i_cfg.zero_low_ticks);
        end
    end

    assign o_out_valid = r_valid;

endmodule

[src/ws2812_pixel_pulse_encoder_core.sv]
// Pixel pulse encoder for a serial LED strip.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one word is either a
// pixel (kind 0) with red, green and blue, or a latch request (kind 1).
// Output channel (o_out_valid / i_out_stall / o_out_data): pulse words, each
// a high time, a low time, the data bit and a last flag.
// A pixel gives 24 pulse words, green then red then blue, MSB first, each
// channel scaled by brightness/255 with rounding. A latch gives one word with
// zero high time and the latch hold as low time.
// The input word passes the multiply stage, the divide stage and then the
// serializer load before its first pulse word is valid.
// The serializer sends one pulse word per cycle unless the receiver stalls, so
// latches pass at one per cycle and a pixel as its 24 pulse words; the lane
// pipeline fills while the serializer works, so the next pixel follows with no gap.
// Reset (synchronous, active low) empties the pipeline and loads the timing
// registers with their defaults. When the receiver stalls, the current pulse
// word holds, the pipeline fills, and then o_in_stall rises. Configuration is
// through the APB port; the user must write it only while the block is idle; the block does not check.
module ws2812_pixel_pulse_encoder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  wpe_pkg::t_in_word                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output wpe_pkg::t_out_word                 o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wpe_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wpe_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wpe_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import wpe_pkg::*;

    t_cfg        cfg;
    t_lane_ctrl  lane_ctrl;
    logic        r_s1_valid;
    logic        r_s1_kind;
    logic        r_s2_valid;
    logic        r_s2_kind;
    logic        s1_free;
    logic        s2_free;
    logic        ser_take;
    logic        in_accept;
    logic [CHAN_W-1:0] lane_in  [NUM_LANES];
    logic [CHAN_W-1:0] lane_out [NUM_LANES];

    wpe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign s2_free    = !r_s2_valid || ser_take;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_stall = !s1_free;
    assign in_accept  = i_in_valid && s1_free;

    assign lane_ctrl.mul_en = s1_free;
    assign lane_ctrl.div_en = s2_free;

    // Lane order matches the transmit order: green, red, blue.
    assign lane_in[0] = i_in_data.green;
    assign lane_in[1] = i_in_data.red;
    assign lane_in[2] = i_in_data.blue;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        wpe_lane u_lane (
            .i_clk        (i_clk),
            .i_value      (lane_in[g]),
            .i_brightness (cfg.brightness),
            .i_ctrl       (lane_ctrl),
            .o_scaled     (lane_out[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= in_accept;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_kind <= i_in_data.kind;
        end
        if (s2_free) begin
            r_s2_kind <= r_s1_kind;
        end
    end

    wpe_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_s2_valid),
        .i_load_kind  (r_s2_kind),
        .i_load_word  ({lane_out[0], lane_out[1], lane_out[2]}),
        .i_cfg        (cfg),
        .i_out_stall  (i_out_stall),
        .o_take       (ser_take),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

[src/wpe_checker.sv]
// Port-level checker for the pixel pulse encoder, bound to the top level.
// Depends on wpe_pkg for the word structs.
module wpe_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input wpe_pkg::t_out_word                 o_out_data
);
    import wpe_pkg::*;

    // Output words hold while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed under stall");

    // Nothing is pending in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // The pulses of one pixel come without gaps.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last && !i_out_stall |=> o_out_valid)
        else $error("gap inside a pixel's pulse train");

    // With no word waiting at the output the input is never stalled.
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output is empty");

    // A one bit uses an eight-bit low time.
    a_one_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bit_value |-> o_out_data.low_ticks[15:8] == 8'd0)
        else $error("one bit with a latch-sized low time");

endmodule

bind ws2812_pixel_pulse_encoder_core wpe_checker u_wpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
